>>> sv/sdip_pkg.sv
// Types and constants shared by the strict decimal integer parser.
package sdip_pkg;

	// Parse phase, one-hot
	typedef enum logic [4:0] {
		PH_LEAD  = 5'b00001,
		PH_SIGN  = 5'b00010,
		PH_DIGIT = 5'b00100,
		PH_TRAIL = 5'b01000,
		PH_ERR   = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic        negative;
		logic [31:0] magnitude;
	} parse_state_t;

	localparam logic [7:0] CH_END   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;

	localparam logic [35:0] POS_LIMIT = 36'd2147483647;
	localparam logic [35:0] NEG_LIMIT = 36'd2147483648;

	localparam parse_state_t STATE_RESET = '{phase: PH_LEAD, negative: 1'b0,
		magnitude: 32'd0};

endpackage

>>> sv/sdip_step.sv
// Next-state and result logic for one character of the parser.
module sdip_step (
	input  sdip_pkg::parse_state_t st,
	input  logic [7:0]             ch,
	output sdip_pkg::parse_state_t nxt,
	output logic signed [31:0]     res_value,
	output logic                   res_error
);
	import sdip_pkg::*;

	logic        is_space;
	logic        is_digit;
	logic [35:0] acc;
	logic [35:0] limit;
	logic        ovf;
	logic        ok;
	parse_state_t dig_st;

	// Character classes
	assign is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

	// magnitude * 10 + digit, checked against the sign's limit
	assign acc = {1'b0, st.magnitude, 3'b000} + {3'b000, st.magnitude, 1'b0}
		+ {32'd0, ch[3:0]};
	assign limit = st.negative ? NEG_LIMIT : POS_LIMIT;
	assign ovf = acc > limit;

	always_comb begin
		dig_st = st;
		if (ovf) begin
			dig_st.phase = PH_ERR;
		end else begin
			dig_st.phase = PH_DIGIT;
			dig_st.magnitude = acc[31:0];
		end
	end

	// Phase transitions; end byte returns to reset
	always_comb begin
		nxt = st;
		if (ch == CH_END) begin
			nxt = STATE_RESET;
		end else begin
			unique case (st.phase)
				PH_LEAD: begin
					if (is_space) begin
						nxt = st;
					end else if (ch == CH_MINUS) begin
						nxt.negative = 1'b1;
						nxt.phase = PH_SIGN;
					end else if (ch == CH_PLUS) begin
						nxt.phase = PH_SIGN;
					end else if (is_digit) begin
						nxt = dig_st;
					end else begin
						nxt.phase = PH_ERR;
					end
				end
				PH_SIGN: begin
					if (is_digit) nxt = dig_st;
					else nxt.phase = PH_ERR;
				end
				PH_DIGIT: begin
					if (is_digit) nxt = dig_st;
					else if (is_space) nxt.phase = PH_TRAIL;
					else nxt.phase = PH_ERR;
				end
				PH_TRAIL: begin
					if (!is_space) nxt.phase = PH_ERR;
				end
				default: begin
					nxt.phase = PH_ERR;
				end
			endcase
		end
	end

	// Result for the end byte
	assign ok = (st.phase == PH_DIGIT) || (st.phase == PH_TRAIL);
	assign res_error = !ok;
	assign res_value = !ok ? 32'sd0 :
		st.negative ? $signed(32'd0 - st.magnitude) : $signed(st.magnitude);

endmodule

>>> sv/strict_decimal_int_parser.sv
// Strict signed 32-bit decimal parser, one character beat per cycle.
// An end byte goes from the input register into the registered result.
// Throughput: one character per cycle; set by the input register and the
// single multiply-by-ten accumulate between it and the parse state.
// Input only stalls while an end byte waits on a full, unread result register.
// Reset (arst_n low) clears the parse state and all valid flags at once.
module strict_decimal_int_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         ch,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic               error
);
	import sdip_pkg::*;

	logic               valid_s1;
	logic [7:0]         ch_s1;
	parse_state_t       st_q;
	parse_state_t       st_nxt;
	logic signed [31:0] res_value;
	logic               res_error;
	logic               is_end;
	logic               process;
	logic               out_valid_q;
	logic signed [31:0] value_q;
	logic               error_q;

	// Stage 1 item is consumed unless it is an end byte facing a blocked output
	assign is_end   = (ch_s1 == CH_END);
	assign process  = valid_s1 && !(is_end && out_valid_q && !out_ready);
	assign in_ready = !valid_s1 || process;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) ch_s1 <= ch;
	end

	sdip_step u_step (
		.st        (st_q),
		.ch        (ch_s1),
		.nxt       (st_nxt),
		.res_value (res_value),
		.res_error (res_error)
	);

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (process) begin
			st_q <= st_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (process && is_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && is_end) begin
			value_q <= res_value;
			error_q <= res_error;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign error     = error_q;

	// Checks
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && error_q |-> value_q == 32'sd0)
		else $error("error result with nonzero value");

	a_stall_end: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && is_end && out_valid_q)
		else $error("input stalled without a blocked end byte");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		process && is_end |=> st_q.phase == PH_LEAD && st_q.magnitude == 32'd0
			&& !st_q.negative)
		else $error("parse state not cleared after end byte");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		process && is_end |=> out_valid_q)
		else $error("end byte gave no result");

endmodule
